// File: sv/itoa_pkg.sv
// Shared types and constants of the signed integer to decimal text converter.
package itoa_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned CharW     = 6;

  typedef logic [3:0]       digit_t;
  typedef logic [CharW-1:0] char_t;

  localparam char_t CHAR_MINUS = 6'd45;
  localparam char_t CHAR_ZERO  = 6'd48;

  // Control shared by every cell of the digit row
  typedef struct packed {
    logic clr;     // zero the digit
    logic dabble;  // add-3 correction, then shift one binary bit in
    logic lift;    // take the lower neighbour's digit
  } cell_ctl_t;

endpackage

// File: sv/itoa_digit_cell.sv
// One BCD digit cell: double-dabble step and digit lift towards the top of the row.
module itoa_digit_cell (
  input  logic                 clk,
  input  itoa_pkg::cell_ctl_t  ctl,
  input  logic                 bit_in,
  input  itoa_pkg::digit_t     digit_in,
  output logic                 bit_out,
  output itoa_pkg::digit_t     digit_out
);

  itoa_pkg::digit_t digit_r;
  itoa_pkg::digit_t digit_nxt;
  itoa_pkg::digit_t adj;

  // Correct by three when the digit would overflow past nine after doubling
  assign adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out   = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.lift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// File: sv/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// One number is taken when start is high and busy is low; the block then
// emits its decimal text one character per beat, most significant first,
// with out_valid high for exactly one cycle per character. The receiver
// cannot stall the output, so every beat must be taken as it appears. A
// negative number is led by '-', zero gives the single character '0', and
// there are no leading zeros; out_last_char marks the final digit. The most
// negative value gives all eleven characters. Busy stays high while a
// number is converted and emitted, so a new number is taken only once busy
// is low, and the time taken is the same whatever its length: the binary
// magnitude is shifted into a row of ten BCD digit cells one bit per cycle
// (double dabble), then the row is lifted towards its top once per cycle,
// once per digit, dropping leading zeros and emitting the rest. The '-'
// leaves on the cycle after the start beat; the last digit leaves in the
// same cycle as busy falls. Nothing is kept from one number to the next.
module signed_int_to_decimal_ascii (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  output logic [5:0]            out_char_code,
  output logic                  out_last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int unsigned NumDigits = itoa_pkg::NumDigits;
  localparam int unsigned WordW     = itoa_pkg::WordW;
  localparam int unsigned BitCntW   = $clog2(WordW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  logic [1:0]          state_r,    state_nxt;
  logic [WordW-1:0]    mag_r,      mag_nxt;
  logic [BitCntW-1:0]  bit_cnt_r,  bit_cnt_nxt;
  logic [DigCntW-1:0]  dig_cnt_r,  dig_cnt_nxt;
  logic                started_r,  started_nxt;
  logic                out_valid_r, out_valid_nxt;
  itoa_pkg::char_t     out_char_r,  out_char_nxt;
  logic                out_last_r,  out_last_nxt;

  itoa_pkg::cell_ctl_t ctl;
  logic                accept;
  logic [WordW-1:0]    value_bits;

  // Carry chain runs upwards for dabble; digits run upwards for lift
  logic                bit_chain [NumDigits+1];
  itoa_pkg::digit_t    digit_w   [NumDigits];
  itoa_pkg::digit_t    lift_in   [NumDigits];
  itoa_pkg::digit_t    top_digit;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign value_bits = in_value;
  assign top_digit  = digit_w[NumDigits-1];

  // Binary magnitude enters the lowest cell, most significant bit first
  assign bit_chain[0] = mag_r[WordW-1];

  genvar gi;
  generate
    for (gi = 0; gi < NumDigits; gi++) begin : g_cell
      if (gi == 0) begin : g_bottom
        assign lift_in[gi] = '0;
      end else begin : g_upper
        assign lift_in[gi] = digit_w[gi-1];
      end

      itoa_digit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (bit_chain[gi]),
        .digit_in  (lift_in[gi]),
        .bit_out   (bit_chain[gi+1]),
        .digit_out (digit_w[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Magnitude in unsigned arithmetic, so the most negative value holds
          mag_nxt     = value_bits[WordW-1] ? (~value_bits + 1'b1) : value_bits;
          bit_cnt_nxt = '0;
          ctl.clr     = 1'b1;
          state_nxt   = ST_CONV;
          if (value_bits[WordW-1]) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = itoa_pkg::CHAR_MINUS;
            out_last_nxt  = 1'b0;
          end
        end
      end

      ST_CONV: begin
        ctl.dabble  = 1'b1;
        mag_nxt     = {mag_r[WordW-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BitCntW'(WordW - 1)) begin
          dig_cnt_nxt = DigCntW'(NumDigits);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end

      ST_EMIT: begin
        ctl.lift    = 1'b1;
        dig_cnt_nxt = dig_cnt_r - 1'b1;
        // Drop leading zeros, but always keep the final digit
        if (started_r || (top_digit != '0) || (dig_cnt_r == DigCntW'(1))) begin
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::CHAR_ZERO + {2'b00, top_digit};
          out_last_nxt  = (dig_cnt_r == DigCntW'(1));
        end
        if (dig_cnt_r == DigCntW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule
